FILE: rtl/qmn_pkg.sv
`timescale 1ns / 1ps

package qmn_pkg;

    localparam int FRAC_BITS = 14;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int NLANE   = 4;
    localparam int PROD_W  = 2 * IN_W;
    localparam int PSUM_W  = PROD_W + 2;
    localparam int MAG_W   = PROD_W + 1;
    localparam int POS_W   = $clog2(MAG_W);
    localparam int NM_W    = 31;
    localparam int SQ_W    = 2 * NM_W;
    localparam int SUM_W   = 64;
    localparam int SQT_W   = SUM_W + 2;
    localparam int ROOT_W  = 32;
    localparam int SSTEP_W = $clog2(ROOT_W);
    localparam int NUM_W   = FRAC_BITS + 34;
    localparam int Q_W     = FRAC_BITS + 2;
    localparam int DSTEP_W = $clog2(Q_W);

    localparam int FRONT_ST = 7;
    localparam int SQRT_ST  = ROOT_W;
    localparam int DIV_ST   = Q_W;
    localparam int NST      = FRONT_ST + SQRT_ST + DIV_ST + 1;

    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    localparam int POS_MAX = 32767;
    localparam int NEG_MAX = 32768;

    typedef struct packed {
        logic [NLANE-1:0][IN_W-1:0] lq;
        logic [NLANE-1:0][IN_W-1:0] rq;
    } qin_t;

    typedef struct packed {
        logic [SUM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
        logic [NLANE-1:0][NM_W-1:0] mag;
        logic [NLANE-1:0]           neg;
        logic                       zero;
    } sq_word_t;

    typedef struct packed {
        logic [ROOT_W-1:0]           len;
        logic [NLANE-1:0][NUM_W-1:0] rem;
        logic [NLANE-1:0][Q_W-1:0]   quo;
        logic [NLANE-1:0]            neg;
        logic                        zero;
    } dv_word_t;

endpackage

FILE: rtl/quaternion_multiply_normalize_core.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Word
// in      | in_valid / in_stall  | left_x..left_w, right_x..right_w
// out     | out_valid / out_stall| prod_x..prod_w, zero_length
//
// One word per cycle sustained while out_stall is low; with 14 fraction bits the stages are
// 7 product/normalize stages, 32 square-root cells, FRAC_BITS+2 divide cells and output.
// The square-root cell row and the divide cell row set the latency.
// Reset clears only the stage valid bits; the pipeline starts empty.
// A stall on out freezes only the full stages behind it; bubbles still close up.
module quaternion_multiply_normalize_core
    import qmn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  left_x,
    input  logic signed [IN_W-1:0]  left_y,
    input  logic signed [IN_W-1:0]  left_z,
    input  logic signed [IN_W-1:0]  left_w,
    input  logic signed [IN_W-1:0]  right_x,
    input  logic signed [IN_W-1:0]  right_y,
    input  logic signed [IN_W-1:0]  right_z,
    input  logic signed [IN_W-1:0]  right_w,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] prod_x,
    output logic signed [OUT_W-1:0] prod_y,
    output logic signed [OUT_W-1:0] prod_z,
    output logic signed [OUT_W-1:0] prod_w,
    output logic                    zero_length
);

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    logic [NST:0]     rdy;
    qin_t             qin;
    sq_word_t         sq_w [SQRT_ST+1];
    dv_word_t         dv_w [DIV_ST+1];
    dv_word_t         dv_end;
    logic [OUT_W-1:0] prod_reg [NLANE];
    logic [OUT_W-1:0] prod_next [NLANE];
    logic             zero_reg;
    logic [32:0]      qx;

    assign rdy[NST] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_next[i];
            end
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NST-1];

    always_comb
    begin
        qin.lq[IX] = left_x;
        qin.lq[IY] = left_y;
        qin.lq[IZ] = left_z;
        qin.lq[IW] = left_w;
        qin.rq[IX] = right_x;
        qin.rq[IY] = right_y;
        qin.rq[IZ] = right_z;
        qin.rq[IW] = right_w;
    end

    qmn_front u_front
    (
        .clk  (clk),
        .en   (rdy[FRONT_ST-1:0]),
        .din  (qin),
        .dout (sq_w[0])
    );

    generate
        for (k = 0; k < SQRT_ST; k++)
        begin : g_sqrt
            qmn_sqrt_cell u_cell
            (
                .clk  (clk),
                .en   (rdy[FRONT_ST+k]),
                .step (SSTEP_W'(ROOT_W - 1 - k)),
                .din  (sq_w[k]),
                .dout (sq_w[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        dv_w[0].len = sq_w[SQRT_ST].root;
        for (int i = 0; i < NLANE; i++)
        begin
            dv_w[0].rem[i] = ({{(NUM_W-NM_W){1'b0}}, sq_w[SQRT_ST].mag[i]} << FRAC_BITS)
                           + NUM_W'(sq_w[SQRT_ST].root >> 1);
            dv_w[0].quo[i] = '0;
        end
        dv_w[0].neg  = sq_w[SQRT_ST].neg;
        dv_w[0].zero = sq_w[SQRT_ST].zero;
    end

    generate
        for (k = 0; k < DIV_ST; k++)
        begin : g_div
            qmn_div_cell u_cell
            (
                .clk  (clk),
                .en   (rdy[FRONT_ST+SQRT_ST+k]),
                .step (DSTEP_W'(Q_W - 1 - k)),
                .din  (dv_w[k]),
                .dout (dv_w[k+1])
            );
        end
    endgenerate

    assign dv_end = dv_w[DIV_ST];

    always_comb
    begin
        qx = '0;
        for (int i = 0; i < NLANE; i++)
        begin
            qx = {{(33-Q_W){1'b0}}, dv_end.quo[i]};
            if (dv_end.zero)
                prod_next[i] = '0;
            else if (dv_end.neg[i])
                prod_next[i] = (qx > 33'(NEG_MAX)) ? OUT_W'(NEG_MAX) : OUT_W'(-qx);
            else
                prod_next[i] = (qx > 33'(POS_MAX)) ? OUT_W'(POS_MAX) : OUT_W'(qx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
        begin
            prod_reg <= prod_next;
            zero_reg <= dv_end.zero;
        end
    end

    assign prod_x      = prod_reg[IX];
    assign prod_y      = prod_reg[IY];
    assign prod_z      = prod_reg[IZ];
    assign prod_w      = prod_reg[IW];
    assign zero_length = zero_reg;

endmodule

FILE: rtl/qmn_front.sv
`timescale 1ns / 1ps

module qmn_front
    import qmn_pkg::*;
(
    input  logic                clk,
    input  logic [FRONT_ST-1:0] en,
    input  qin_t                din,
    output sq_word_t            dout
);

    logic signed [PROD_W-1:0] pr_reg [NLANE][NLANE];
    logic signed [PSUM_W-1:0] p_reg [NLANE];
    logic [MAG_W-1:0]         mag3_reg [NLANE];
    logic [MAG_W-1:0]         max3_reg;
    logic [NLANE-1:0]         neg3_reg;
    logic [MAG_W-1:0]         mag4_reg [NLANE];
    logic [POS_W-1:0]         pos4_reg;
    logic                     zero4_reg;
    logic [NLANE-1:0]         neg4_reg;
    logic [NM_W-1:0]          m5_reg [NLANE];
    logic                     zero5_reg;
    logic [NLANE-1:0]         neg5_reg;
    logic [SQ_W-1:0]          sq6_reg [NLANE];
    logic [NM_W-1:0]          m6_reg [NLANE];
    logic                     zero6_reg;
    logic [NLANE-1:0]         neg6_reg;
    logic [SUM_W-1:0]         sum7_reg;
    logic [NM_W-1:0]          m7_reg [NLANE];
    logic                     zero7_reg;
    logic [NLANE-1:0]         neg7_reg;

    logic signed [PSUM_W-1:0] p_next [NLANE];
    logic [MAG_W-1:0]         mag_next [NLANE];
    logic [MAG_W-1:0]         max_next;
    logic [POS_W-1:0]         pos_next;
    logic [NM_W-1:0]          m_next [NLANE];
    logic [2*PROD_W-1:0]      wide;

    always_comb
    begin
        p_next[IX] = PSUM_W'(pr_reg[IW][IX]) + PSUM_W'(pr_reg[IX][IW])
                   + PSUM_W'(pr_reg[IY][IZ]) - PSUM_W'(pr_reg[IZ][IY]);
        p_next[IY] = PSUM_W'(pr_reg[IW][IY]) + PSUM_W'(pr_reg[IY][IW])
                   + PSUM_W'(pr_reg[IZ][IX]) - PSUM_W'(pr_reg[IX][IZ]);
        p_next[IZ] = PSUM_W'(pr_reg[IW][IZ]) + PSUM_W'(pr_reg[IZ][IW])
                   + PSUM_W'(pr_reg[IX][IY]) - PSUM_W'(pr_reg[IY][IX]);
        p_next[IW] = PSUM_W'(pr_reg[IW][IW]) - PSUM_W'(pr_reg[IX][IX])
                   - PSUM_W'(pr_reg[IY][IY]) - PSUM_W'(pr_reg[IZ][IZ]);
    end

    always_comb
    begin
        max_next = '0;
        for (int i = 0; i < NLANE; i++)
        begin
            mag_next[i] = p_reg[i][PSUM_W-1] ? MAG_W'(-p_reg[i]) : MAG_W'(p_reg[i]);
            if (mag_next[i] > max_next)
                max_next = mag_next[i];
        end
    end

    always_comb
    begin
        pos_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (max3_reg[b])
                pos_next = POS_W'(b);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            wide = {{(2*PROD_W-MAG_W){1'b0}}, mag4_reg[i]};
            if (pos4_reg > POS_W'(NM_W - 1))
                wide = wide >> (pos4_reg - POS_W'(NM_W - 1));
            else
                wide = wide << (POS_W'(NM_W - 1) - pos4_reg);
            m_next[i] = wide[NM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int a = 0; a < NLANE; a++)
                for (int b = 0; b < NLANE; b++)
                    pr_reg[a][b] <= $signed(din.lq[a]) * $signed(din.rq[b]);
        end
        if (en[1])
        begin
            for (int i = 0; i < NLANE; i++)
                p_reg[i] <= p_next[i];
        end
        if (en[2])
        begin
            for (int i = 0; i < NLANE; i++)
            begin
                mag3_reg[i] <= mag_next[i];
                neg3_reg[i] <= p_reg[i][PSUM_W-1];
            end
            max3_reg <= max_next;
        end
        if (en[3])
        begin
            mag4_reg  <= mag3_reg;
            pos4_reg  <= pos_next;
            zero4_reg <= (max3_reg == '0);
            neg4_reg  <= neg3_reg;
        end
        if (en[4])
        begin
            m5_reg    <= m_next;
            zero5_reg <= zero4_reg;
            neg5_reg  <= neg4_reg;
        end
        if (en[5])
        begin
            for (int i = 0; i < NLANE; i++)
                sq6_reg[i] <= SQ_W'(m5_reg[i]) * SQ_W'(m5_reg[i]);
            m6_reg    <= m5_reg;
            zero6_reg <= zero5_reg;
            neg6_reg  <= neg5_reg;
        end
        if (en[6])
        begin
            sum7_reg  <= SUM_W'(sq6_reg[0]) + SUM_W'(sq6_reg[1])
                       + SUM_W'(sq6_reg[2]) + SUM_W'(sq6_reg[3]);
            m7_reg    <= m6_reg;
            zero7_reg <= zero6_reg;
            neg7_reg  <= neg6_reg;
        end
    end

    always_comb
    begin
        dout.rem  = sum7_reg;
        dout.root = '0;
        for (int i = 0; i < NLANE; i++)
            dout.mag[i] = m7_reg[i];
        dout.neg  = neg7_reg;
        dout.zero = zero7_reg;
    end

endmodule

FILE: rtl/qmn_sqrt_cell.sv
`timescale 1ns / 1ps

module qmn_sqrt_cell
    import qmn_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [SSTEP_W-1:0] step,
    input  sq_word_t           din,
    output sq_word_t           dout
);

    sq_word_t           word_reg;
    sq_word_t           word_next;
    logic [SSTEP_W:0]   sh_a;
    logic [SSTEP_W:0]   sh_b;
    logic [SQT_W-1:0]   trial;
    logic [SQT_W-1:0]   rem_x;

    always_comb
    begin
        sh_a      = {1'b0, step} + 1'b1;
        sh_b      = {step, 1'b0};
        trial     = ({{(SQT_W-ROOT_W){1'b0}}, din.root} << sh_a)
                  + (SQT_W'(1) << sh_b);
        rem_x     = {{(SQT_W-SUM_W){1'b0}}, din.rem};
        word_next = din;
        if (rem_x >= trial)
        begin
            word_next.rem  = SUM_W'(rem_x - trial);
            word_next.root = din.root | (ROOT_W'(1) << step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign dout = word_reg;

endmodule

FILE: rtl/qmn_div_cell.sv
`timescale 1ns / 1ps

module qmn_div_cell
    import qmn_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DSTEP_W-1:0] step,
    input  dv_word_t           din,
    output dv_word_t           dout
);

    dv_word_t         word_reg;
    dv_word_t         word_next;
    logic [NUM_W-1:0] dsor;

    always_comb
    begin
        dsor      = {{(NUM_W-ROOT_W){1'b0}}, din.len} << step;
        word_next = din;
        for (int i = 0; i < NLANE; i++)
        begin
            if (din.rem[i] >= dsor)
            begin
                word_next.rem[i] = din.rem[i] - dsor;
                word_next.quo[i] = din.quo[i] | (Q_W'(1) << step);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign dout = word_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qmn_pkg::*;

    localparam int LATENCY   = 56;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 800;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               zl;
    } unit_quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [IN_W-1:0] left_x, left_y, left_z, left_w;
    logic signed [IN_W-1:0] right_x, right_y, right_z, right_w;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] prod_x, prod_y, prod_z, prod_w;
    logic zero_length;

    unit_quat_t expected_q[$];
    int  errors;
    int  idle_cycles;
    bit  stall_enable;

    quaternion_multiply_normalize_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_x(left_x), .left_y(left_y), .left_z(left_z), .left_w(left_w),
        .right_x(right_x), .right_y(right_y), .right_z(right_z), .right_w(right_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .prod_x(prod_x), .prod_y(prod_y), .prod_z(prod_z), .prod_w(prod_w),
        .zero_length(zero_length)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem, root, bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic unit_quat_t hamilton_unit(
        input logic signed [15:0] lx, ly, lz, lw, rx, ry, rz, rw);
        longint p[4];
        longint unsigned m[4];
        longint unsigned mx, sum, len, q;
        longint v;
        logic signed [15:0] o[4];
        unit_quat_t r;
        p[0] = lw * rx + lx * rw + ly * rz - lz * ry;
        p[1] = lw * ry + ly * rw + lz * rx - lx * rz;
        p[2] = lw * rz + lz * rw + lx * ry - ly * rx;
        p[3] = lw * rw - lx * rx - ly * ry - lz * rz;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = p[i] < 0 ? -p[i] : p[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            r.x = 0; r.y = 0; r.z = 0; r.w = 0; r.zl = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 31))
        begin
            mx >>= 1;
            for (int i = 0; i < 4; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx <<= 1;
            for (int i = 0; i < 4; i++)
                m[i] <<= 1;
        end
        for (int i = 0; i < 4; i++)
            sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 4; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            if (p[i] < 0)
                v = q > NEG_MAX ? -NEG_MAX : -longint'(q);
            else
                v = q > POS_MAX ? POS_MAX : longint'(q);
            o[i] = v[15:0];
        end
        r.x = o[0]; r.y = o[1]; r.z = o[2]; r.w = o[3]; r.zl = 1'b0;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_word(input logic signed [15:0] lx, ly, lz, lw, rx, ry, rz, rw);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        left_x <= lx; left_y <= ly; left_z <= lz; left_w <= lw;
        right_x <= rx; right_y <= ry; right_z <= rz; right_w <= rw;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(hamilton_unit(lx, ly, lz, lw, rx, ry, rz, rw));
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
    endtask

    task automatic test_extremes();
        logic signed [15:0] ext[5];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shffff};
        send_word(0, 0, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, 0, 16'sh4000, 0, 0, 0, 0);
        send_word(0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000);
        send_word(16'sh4000, 0, 0, 0, 0, 16'sh4000, 0, 0);
        send_word(0, 0, 0, 1, 0, 0, 0, 1);
        send_word(1, 0, 0, 0, 0, 0, 0, 1);
        for (int i = 0; i < 5; i++)
            send_word(ext[i], ext[i], ext[i], ext[i], ext[4-i], ext[i], ext[4-i], ext[i]);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_word(0, 0, 16'sh8000, 0, 0, 0, 0, 16'sh7fff);
    endtask

    task automatic test_pause_drain();
        send_word(16'sh1234, 16'sh8765, 16'sh0f0f, 16'sh7000,
                  16'shf000, 16'sh0101, 16'sh2222, 16'sh9999);
        wait_drain();
        send_word(16'sh0003, 16'shfffd, 16'sh0002, 16'sh0001,
                  16'sh0001, 16'sh0000, 16'shffff, 16'sh0004);
    endtask

    task automatic test_random();
        logic signed [15:0] f[8];
        int mode;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++)
            begin
                case (mode)
                    0: f[i] = $urandom_range(0, 15) - 8;
                    1: f[i] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                    default: f[i] = $urandom();
                endcase
                if (mode == 1 && $urandom_range(0, 3) == 0)
                    f[i] = 0;
            end
            send_word(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
        end
    endtask

    always @(negedge clk)
    begin
        if (!stall_enable)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 49) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 9) != 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        unit_quat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (prod_x !== e.x)
                begin
                    $error("prod_x expected %0d actual %0d", e.x, prod_x);
                    errors++;
                end
                if (prod_y !== e.y)
                begin
                    $error("prod_y expected %0d actual %0d", e.y, prod_y);
                    errors++;
                end
                if (prod_z !== e.z)
                begin
                    $error("prod_z expected %0d actual %0d", e.z, prod_z);
                    errors++;
                end
                if (prod_w !== e.w)
                begin
                    $error("prod_w expected %0d actual %0d", e.w, prod_w);
                    errors++;
                end
                if (zero_length !== e.zl)
                begin
                    $error("zero_length expected %0d actual %0d", e.zl, zero_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {left_x, left_y, left_z, left_w} = '0;
        {right_x, right_y, right_z, right_w} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        stall_enable = 1'b1;
        test_pause_drain();
        test_random();
        wait_drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
